// ----- rtl/rrsf_pkg.sv -----
// ----------------------------------------------------------------------------
// rrsf_pkg
// Shared types, constants, corner tables and inset helpers of the
// rounded rectangle span filler.
// ----------------------------------------------------------------------------
package rrsf_pkg;

   localparam int DISPLAY_COLS = 256;
   localparam int DISPLAY_ROWS = 64;
   localparam int MAX_RADIUS   = 8;

   localparam int COL_W  = $clog2(DISPLAY_COLS + 1);
   localparam int ROW_W  = 6;
   localparam int ROWC_W = $clog2(DISPLAY_ROWS + 1);
   localparam int ALU_W  = 18;
   localparam int RAD_W  = 4;
   localparam int CROP_W = 4;
   localparam int TDIST_W = 8;
   localparam int BDIST_W = 9;

   localparam int BIT_TL = 0;
   localparam int BIT_TR = 1;
   localparam int BIT_BL = 2;
   localparam int BIT_BR = 3;

   localparam logic [7:0] COLOR_WHITE = 8'hFF;

   localparam logic [31:0] TOP_INSETS [0:MAX_RADIUS] = '{
      32'h0, 32'h01, 32'h01, 32'h12, 32'h113, 32'h123, 32'h1234, 32'h11235, 32'h112346
   };
   localparam logic [31:0] BOTTOM_INSETS [0:MAX_RADIUS] = '{
      32'h0, 32'h01, 32'h10, 32'h210, 32'h3110, 32'h32100, 32'h432100, 32'h5321100,
      32'h64321100
   };

   typedef enum logic [2:0] {
      REG_ORIGIN_X    = 3'd0,
      REG_ORIGIN_Y    = 3'd1,
      REG_CLIP_LEFT   = 3'd2,
      REG_CLIP_TOP    = 3'd3,
      REG_CLIP_RIGHT  = 3'd4,
      REG_CLIP_BOTTOM = 3'd5
   } csr_index_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] result;
      logic             lt;
   } alu_rsp_type;

   typedef struct packed {
      logic [COL_W-1:0]   x0;
      logic [COL_W-1:0]   cw;
      logic [ROW_W-1:0]   y0;
      logic [ROWC_W-1:0]  y1;
      logic [CROP_W-1:0]  lcrop;
      logic [CROP_W-1:0]  rcrop;
      logic [RAD_W-1:0]   radius;
      logic [3:0]         mask;
      logic [7:0]         color;
      logic [TDIST_W-1:0] dt;
      logic [BDIST_W-1:0] db;
   } span_setup_type;

   function automatic logic [3:0] inset_nibble(input logic [31:0] tbl,
                                               input logic [TDIST_W-1:0] k);
      logic [3:0] res;
      res = 4'd0;
      if (k < TDIST_W'(8)) res = tbl[{k[2:0], 2'b00} +: 4];
      return res;
   endfunction

   // bottom table wins once the row reaches the bottom corner
   function automatic logic [3:0] corner_inset(input logic [3:0] mask,
                                               input int top_bit,
                                               input int bot_bit,
                                               input logic [RAD_W-1:0] radius,
                                               input logic [TDIST_W-1:0] dt,
                                               input logic [BDIST_W-1:0] db);
      logic [3:0] res;
      res = 4'd0;
      if (mask[bot_bit] && !db[BDIST_W-1])
         res = inset_nibble(BOTTOM_INSETS[radius], db[TDIST_W-1:0]);
      else if (mask[top_bit])
         res = inset_nibble(TOP_INSETS[radius], dt);
      return res;
   endfunction

endpackage

// ----- rtl/rounded_rect_span_fill_core.sv -----
// ----------------------------------------------------------------------------
// rounded_rect_span_fill_core
// Rounded rectangle fill: clamps radius, clips, then emits one span per row.
//
//   channel | ports                                        | role
//   req     | req_valid req_stall req_rect_* req_corner_*  | fill command in
//           | req_fill_color                               |
//   rsp     | rsp_valid rsp_stall rsp_row rsp_span_start   | span out
//           | rsp_span_end rsp_color rsp_last              |
//   csr     | csr_wr_en csr_index csr_wdata                | register write
//
// An item runs its setup steps on the shared adder, then emits one span per
// cycle while the output is not stalled.
// Setup length is set by the step sequence through the single adder.
// Synchronous reset restores the register defaults and empties the output.
// A stalled span holds the row walk; the next item is taken once the walk ends.
// ----------------------------------------------------------------------------
module rounded_rect_span_fill_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [15:0]                 req_rect_x,
   input  logic [15:0]                 req_rect_y,
   input  logic [14:0]                 req_rect_w,
   input  logic [14:0]                 req_rect_h,
   input  logic [3:0]                  req_corner_radius,
   input  logic [3:0]                  req_corner_select,
   input  logic [7:0]                  req_fill_color,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [rrsf_pkg::ROW_W-1:0]  rsp_row,
   output logic [rrsf_pkg::COL_W-1:0]  rsp_span_start,
   output logic [rrsf_pkg::COL_W-1:0]  rsp_span_end,
   output logic [7:0]                  rsp_color,
   output logic                        rsp_last,
   input  logic                        csr_wr_en,
   input  logic [2:0]                  csr_index,
   input  logic [15:0]                 csr_wdata
);
   import rrsf_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_AX, ST_AY, ST_AXW, ST_AYH, ST_WH, ST_RAD, ST_BOT, ST_X0,
      ST_X1A, ST_X1B, ST_Y0, ST_Y1A, ST_Y1B, ST_CHKX, ST_CHKY, ST_LCROP,
      ST_RCROP, ST_CW, ST_DT, ST_DB, ST_ROWS
   } state_type;

   state_type        state_ff;

   logic [15:0]      origin_x_ff;
   logic [15:0]      origin_y_ff;
   logic [8:0]       clip_left_ff;
   logic [6:0]       clip_top_ff;
   logic [8:0]       clip_right_ff;
   logic [6:0]       clip_bottom_ff;

   logic [15:0]      rx_ff;
   logic [15:0]      ry_ff;
   logic [14:0]      w_ff;
   logic [14:0]      h_ff;
   logic [14:0]      m_ff;
   logic [RAD_W-1:0] r_ff;
   logic [3:0]       mask_ff;
   logic [7:0]       color_ff;
   logic [ALU_W-1:0] ax_ff;
   logic [ALU_W-1:0] ay_ff;
   logic [ALU_W-1:0] axw_ff;
   logic [ALU_W-1:0] ayh_ff;
   logic [ALU_W-1:0] bot_ff;
   logic [ALU_W-1:0] x0_ff;
   logic [ALU_W-1:0] x1_ff;
   logic [ALU_W-1:0] y0_ff;
   logic [ALU_W-1:0] y1_ff;
   logic [CROP_W-1:0] lcrop_ff;
   logic [CROP_W-1:0] rcrop_ff;
   logic [COL_W-1:0] cw_ff;
   logic [TDIST_W-1:0] dt_ff;
   span_setup_type   setup_ff;
   logic             start_ff;

   alu_req_type      alu_req;
   alu_rsp_type      alu_rsp;
   logic [RAD_W-1:0] rad_pick;
   logic [RAD_W-1:0] rad_in;
   logic [BDIST_W-1:0] db_in;
   logic [CROP_W-1:0] crop_in;
   logic [TDIST_W-1:0] dt_in;
   logic             span_done;

   function automatic logic [ALU_W-1:0] sx16(input logic [15:0] v);
      return {{(ALU_W-16){v[15]}}, v};
   endfunction

   // operand select for the shared adder
   always_comb begin
      alu_req.op = ALU_SUB;
      alu_req.a  = '0;
      alu_req.b  = '0;
      case (state_ff)
         ST_AX:    begin alu_req.op = ALU_ADD; alu_req.a = sx16(rx_ff);
                         alu_req.b = sx16(origin_x_ff); end
         ST_AY:    begin alu_req.op = ALU_ADD; alu_req.a = sx16(ry_ff);
                         alu_req.b = sx16(origin_y_ff); end
         ST_AXW:   begin alu_req.op = ALU_ADD; alu_req.a = ax_ff;
                         alu_req.b = ALU_W'(w_ff); end
         ST_AYH:   begin alu_req.op = ALU_ADD; alu_req.a = ay_ff;
                         alu_req.b = ALU_W'(h_ff); end
         ST_WH:    begin alu_req.a = ALU_W'(w_ff); alu_req.b = ALU_W'(h_ff); end
         ST_RAD:   begin alu_req.a = ALU_W'(m_ff); alu_req.b = ALU_W'({r_ff, 1'b0}); end
         ST_BOT:   begin alu_req.a = ayh_ff; alu_req.b = ALU_W'(r_ff); end
         ST_X0:    begin alu_req.a = ax_ff; alu_req.b = ALU_W'(clip_left_ff); end
         ST_X1A:   begin alu_req.a = axw_ff; alu_req.b = ALU_W'(clip_right_ff); end
         ST_X1B:   begin alu_req.a = x1_ff; alu_req.b = ALU_W'(DISPLAY_COLS); end
         ST_Y0:    begin alu_req.a = ay_ff; alu_req.b = ALU_W'(clip_top_ff); end
         ST_Y1A:   begin alu_req.a = ayh_ff; alu_req.b = ALU_W'(clip_bottom_ff); end
         ST_Y1B:   begin alu_req.a = y1_ff; alu_req.b = ALU_W'(DISPLAY_ROWS); end
         ST_CHKX:  begin alu_req.a = x0_ff; alu_req.b = x1_ff; end
         ST_CHKY:  begin alu_req.a = y0_ff; alu_req.b = y1_ff; end
         ST_LCROP: begin alu_req.a = x0_ff; alu_req.b = ax_ff; end
         ST_RCROP: begin alu_req.a = axw_ff; alu_req.b = x1_ff; end
         ST_CW:    begin alu_req.a = x1_ff; alu_req.b = x0_ff; end
         ST_DT:    begin alu_req.a = y0_ff; alu_req.b = ay_ff; end
         ST_DB:    begin alu_req.a = y0_ff; alu_req.b = bot_ff; end
         default:  begin alu_req.a = '0; alu_req.b = '0; end
      endcase
   end

   rrsf_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   // saturating views of the adder result
   always_comb begin
      if (mask_ff == 4'd0) begin
         rad_pick = '0;
      end else if (alu_rsp.lt) begin
         rad_pick = m_ff[RAD_W:1];
      end else begin
         rad_pick = r_ff;
      end
      rad_in  = (rad_pick > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : rad_pick;
      crop_in = (|alu_rsp.result[ALU_W-1:CROP_W]) ? '1 : alu_rsp.result[CROP_W-1:0];
      dt_in   = (|alu_rsp.result[ALU_W-1:TDIST_W-1]) ? TDIST_W'(127)
                                                      : alu_rsp.result[TDIST_W-1:0];
      if (alu_rsp.result[ALU_W-1]) begin
         db_in = (&alu_rsp.result[ALU_W-1:BDIST_W-2]) ? alu_rsp.result[BDIST_W-1:0]
                                                      : BDIST_W'(9'h180);
      end else begin
         db_in = (|alu_rsp.result[ALU_W-2:BDIST_W-2]) ? BDIST_W'(127)
                                                      : alu_rsp.result[BDIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         start_ff       <= 1'b0;
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         clip_left_ff   <= '0;
         clip_top_ff    <= '0;
         clip_right_ff  <= 9'd256;
         clip_bottom_ff <= 7'd64;
      end else begin
         start_ff <= 1'b0;
         if (csr_wr_en) begin
            case (csr_index)
               REG_ORIGIN_X:    origin_x_ff    <= csr_wdata;
               REG_ORIGIN_Y:    origin_y_ff    <= csr_wdata;
               REG_CLIP_LEFT:   clip_left_ff   <= csr_wdata[8:0];
               REG_CLIP_TOP:    clip_top_ff    <= csr_wdata[6:0];
               REG_CLIP_RIGHT:  clip_right_ff  <= csr_wdata[8:0];
               REG_CLIP_BOTTOM: clip_bottom_ff <= csr_wdata[6:0];
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  rx_ff    <= req_rect_x;
                  ry_ff    <= req_rect_y;
                  w_ff     <= req_rect_w;
                  h_ff     <= req_rect_h;
                  r_ff     <= req_corner_radius;
                  mask_ff  <= req_corner_select;
                  color_ff <= (req_fill_color[7:6] == 2'b00) ? COLOR_WHITE : req_fill_color;
                  state_ff <= ST_AX;
               end
            end
            ST_AX:  begin ax_ff  <= alu_rsp.result; state_ff <= ST_AY;  end
            ST_AY:  begin ay_ff  <= alu_rsp.result; state_ff <= ST_AXW; end
            ST_AXW: begin axw_ff <= alu_rsp.result; state_ff <= ST_AYH; end
            ST_AYH: begin ayh_ff <= alu_rsp.result; state_ff <= ST_WH;  end
            ST_WH: begin
               m_ff     <= alu_rsp.lt ? w_ff : h_ff;
               state_ff <= ST_RAD;
            end
            ST_RAD: begin r_ff <= rad_in; state_ff <= ST_BOT; end
            ST_BOT: begin bot_ff <= alu_rsp.result; state_ff <= ST_X0; end
            ST_X0: begin
               x0_ff    <= alu_rsp.lt ? ALU_W'(clip_left_ff) : ax_ff;
               state_ff <= ST_X1A;
            end
            ST_X1A: begin
               x1_ff    <= alu_rsp.lt ? axw_ff : ALU_W'(clip_right_ff);
               state_ff <= ST_X1B;
            end
            ST_X1B: begin
               if (!alu_rsp.lt) x1_ff <= ALU_W'(DISPLAY_COLS);
               state_ff <= ST_Y0;
            end
            ST_Y0: begin
               y0_ff    <= alu_rsp.lt ? ALU_W'(clip_top_ff) : ay_ff;
               state_ff <= ST_Y1A;
            end
            ST_Y1A: begin
               y1_ff    <= alu_rsp.lt ? ayh_ff : ALU_W'(clip_bottom_ff);
               state_ff <= ST_Y1B;
            end
            ST_Y1B: begin
               if (!alu_rsp.lt) y1_ff <= ALU_W'(DISPLAY_ROWS);
               state_ff <= ST_CHKX;
            end
            ST_CHKX:  state_ff <= alu_rsp.lt ? ST_CHKY : ST_IDLE;
            ST_CHKY:  state_ff <= alu_rsp.lt ? ST_LCROP : ST_IDLE;
            ST_LCROP: begin lcrop_ff <= crop_in; state_ff <= ST_RCROP; end
            ST_RCROP: begin rcrop_ff <= crop_in; state_ff <= ST_CW; end
            ST_CW: begin
               cw_ff    <= alu_rsp.result[COL_W-1:0];
               state_ff <= ST_DT;
            end
            ST_DT: begin dt_ff <= dt_in; state_ff <= ST_DB; end
            ST_DB: begin
               setup_ff.x0     <= x0_ff[COL_W-1:0];
               setup_ff.cw     <= cw_ff;
               setup_ff.y0     <= y0_ff[ROW_W-1:0];
               setup_ff.y1     <= y1_ff[ROWC_W-1:0];
               setup_ff.lcrop  <= lcrop_ff;
               setup_ff.rcrop  <= rcrop_ff;
               setup_ff.radius <= r_ff;
               setup_ff.mask   <= mask_ff;
               setup_ff.color  <= color_ff;
               setup_ff.dt     <= dt_ff;
               setup_ff.db     <= db_in;
               start_ff        <= 1'b1;
               state_ff        <= ST_ROWS;
            end
            ST_ROWS:  if (span_done) state_ff <= ST_IDLE;
            default:  state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   rrsf_span u_span (
      .clock          (clock),
      .reset          (reset),
      .start          (start_ff),
      .setup          (setup_ff),
      .done           (span_done),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_row        (rsp_row),
      .rsp_span_start (rsp_span_start),
      .rsp_span_end   (rsp_span_end),
      .rsp_color      (rsp_color),
      .rsp_last       (rsp_last)
   );

endmodule

// ----- rtl/rrsf_alu.sv -----
// ----------------------------------------------------------------------------
// rrsf_alu
// Shared add / subtract unit with signed less-than flag.
// ----------------------------------------------------------------------------
module rrsf_alu (
   input  rrsf_pkg::alu_req_type req,
   output rrsf_pkg::alu_rsp_type rsp
);
   import rrsf_pkg::*;

   logic [ALU_W:0] a_ext;
   logic [ALU_W:0] b_ext;
   logic [ALU_W:0] sum;
   logic [ALU_W:0] diff;

   assign a_ext = {req.a[ALU_W-1], req.a};
   assign b_ext = {req.b[ALU_W-1], req.b};
   assign sum   = a_ext + b_ext;
   assign diff  = a_ext - b_ext;

   assign rsp.result = (req.op == ALU_ADD) ? sum[ALU_W-1:0] : diff[ALU_W-1:0];
   assign rsp.lt     = diff[ALU_W];

endmodule

// ----- rtl/rrsf_span.sv -----
// ----------------------------------------------------------------------------
// rrsf_span
// Row walker: one span per cycle while the output is not stalled, from the clipped setup, with output register.
// ----------------------------------------------------------------------------
module rrsf_span (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  rrsf_pkg::span_setup_type      setup,
   output logic                          done,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rrsf_pkg::ROW_W-1:0]    rsp_row,
   output logic [rrsf_pkg::COL_W-1:0]    rsp_span_start,
   output logic [rrsf_pkg::COL_W-1:0]    rsp_span_end,
   output logic [7:0]                    rsp_color,
   output logic                          rsp_last
);
   import rrsf_pkg::*;

   span_setup_type     setup_ff;
   logic               busy_ff;
   logic [ROW_W-1:0]   y_ff;
   logic [TDIST_W-1:0] dt_ff;
   logic [BDIST_W-1:0] db_ff;

   logic               rsp_valid_ff;
   logic [ROW_W-1:0]   rsp_row_ff;
   logic [COL_W-1:0]   rsp_start_ff;
   logic [COL_W-1:0]   rsp_end_ff;
   logic [7:0]         rsp_color_ff;
   logic               rsp_last_ff;

   logic               advance;
   logic               last_row;
   logic [3:0]         li;
   logic [3:0]         ri;
   logic [CROP_W-1:0]  ls;
   logic [CROP_W-1:0]  rs;
   logic [CROP_W:0]    trim;
   logic [COL_W-1:0]   width;
   logic [COL_W-1:0]   sx;
   logic [COL_W-1:0]   ex;

   always_comb begin
      advance  = busy_ff && (!rsp_valid_ff || !rsp_stall);
      last_row = (ROWC_W'(y_ff) + ROWC_W'(1)) == setup_ff.y1;
      li = corner_inset(setup_ff.mask, BIT_TL, BIT_BL, setup_ff.radius, dt_ff, db_ff);
      ri = corner_inset(setup_ff.mask, BIT_TR, BIT_BR, setup_ff.radius, dt_ff, db_ff);
      ls = (li > setup_ff.lcrop) ? li - setup_ff.lcrop : '0;
      rs = (ri > setup_ff.rcrop) ? ri - setup_ff.rcrop : '0;
      trim = {1'b0, ls} + {1'b0, rs};
      if (COL_W'(trim) < setup_ff.cw) begin
         width = setup_ff.cw - COL_W'(trim);
      end else begin
         width = '0;
      end
      sx = setup_ff.x0 + COL_W'(ls);
      ex = sx + width;
      done = advance && last_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (start) begin
            busy_ff  <= 1'b1;
            setup_ff <= setup;
            y_ff     <= setup.y0;
            dt_ff    <= setup.dt;
            db_ff    <= setup.db;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            rsp_row_ff   <= y_ff;
            rsp_start_ff <= sx;
            rsp_end_ff   <= ex;
            rsp_color_ff <= setup_ff.color;
            rsp_last_ff  <= last_row;
            y_ff         <= y_ff + ROW_W'(1);
            dt_ff        <= dt_ff + TDIST_W'(1);
            db_ff        <= db_ff + BDIST_W'(1);
            if (last_row) busy_ff <= 1'b0;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row        = rsp_row_ff;
   assign rsp_span_start = rsp_start_ff;
   assign rsp_span_end   = rsp_end_ff;
   assign rsp_color      = rsp_color_ff;
   assign rsp_last       = rsp_last_ff;

   a_done_marks_last: assert property (@(posedge clock) disable iff (reset)
      done |=> (rsp_valid && rsp_last))
      else $error("final span not flagged last");

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("new rectangle started while rows pending");

   a_span_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_span_end >= rsp_span_start))
      else $error("span end before span start");

   a_keep_walking: assert property (@(posedge clock) disable iff (reset)
      (advance && !last_row) |=> busy_ff)
      else $error("row walk stopped early");

endmodule
